// ===== rtl/bicubic_cell_interpolator_macros.svh =====
// assertion macros for the bicubic cell interpolator checker
// no dependencies; included by files that hold concurrent assertions
`ifndef BICUBIC_CELL_INTERPOLATOR_MACROS_SVH
`define BICUBIC_CELL_INTERPOLATOR_MACROS_SVH

// same-cycle implication, checking suspended while reset is high
`define BCI_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checking suspended while reset is high
`define BCI_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after reset
`define BCI_ASSERT_RST(name, clk, rst, cons, msg) \
  name: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bci_pkg.sv =====
// shared types and constants for the bicubic cell interpolator
// no dependencies; imported by every module of the block
`default_nettype none

package bci_pkg;

  // extra fraction bits carried by samples in the row pass
  localparam int EXTRA_BITS = 8;
  // width of the signed output value
  localparam int OUT_BITS = 18;

  // row index within a 4x4 cell
  localparam int ROW_IDX_BITS = 2;
  localparam logic [ROW_IDX_BITS-1:0] LAST_ROW = 2'd3;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // cubic sequencer states of the back part
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL3,
    ST_ADD3,
    ST_MUL2,
    ST_ADD2,
    ST_MUL1,
    ST_ADD1,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/bci_fifo.sv =====
// small register queue between the front and back parts
// depends on bci_pkg for the fill status struct
`default_nettype none

module bci_fifo #(
  parameter int WIDTH = 98,
  parameter int DEPTH = 2
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  wire  [WIDTH-1:0]        wr_data,
  input  wire                     pop,
  output logic [WIDTH-1:0]        rd_data,
  output bci_pkg::fifo_status_t   status
);
  import bci_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // status from the fill count
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign rd_data      = mem[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bci_front.sv =====
// front part: accepts row items, tags each with its row index in the cell
// depends on bci_pkg; feeds bci_fifo
`default_nettype none

module bci_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16,
  parameter int ENTRY_W     = 4 * SAMPLE_BITS + 2 * FRAC_BITS + bci_pkg::ROW_IDX_BITS
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      sample_valid,
  output logic                     sample_stall,
  input  wire  [SAMPLE_BITS-1:0]   sample_0,
  input  wire  [SAMPLE_BITS-1:0]   sample_1,
  input  wire  [SAMPLE_BITS-1:0]   sample_2,
  input  wire  [SAMPLE_BITS-1:0]   sample_3,
  input  wire  [FRAC_BITS-1:0]     frac_h,
  input  wire  [FRAC_BITS-1:0]     frac_v,
  input  bci_pkg::fifo_status_t    status,
  output logic                     push,
  output logic [ENTRY_W-1:0]       entry
);
  import bci_pkg::*;

  logic [ROW_IDX_BITS-1:0] row_count;

  // stall while the queue has no room
  assign sample_stall = status.full;
  assign push         = sample_valid && !status.full;

  // queue entry: fractions, samples and row index
  assign entry = {frac_v, frac_h, sample_3, sample_2, sample_1, sample_0, row_count};

  // row index wraps after the last row of a cell
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
    end else if (push) begin
      row_count <= (row_count == LAST_ROW) ? '0 : row_count + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bci_back.sv =====
// back part: shared cubic sequencer for row and column passes, output register
// depends on bci_pkg; reads entries from bci_fifo
`default_nettype none

module bci_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16,
  parameter int ENTRY_W     = 4 * SAMPLE_BITS + 2 * FRAC_BITS + bci_pkg::ROW_IDX_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  [ENTRY_W-1:0]                   entry,
  input  bci_pkg::fifo_status_t                status,
  output logic                                 pop,
  output logic                                 value_valid,
  input  wire                                  value_stall,
  output logic signed [bci_pkg::OUT_BITS-1:0]  value
);
  import bci_pkg::*;

  // datapath, row result and product widths
  localparam int CW = SAMPLE_BITS + 14;
  localparam int RW = SAMPLE_BITS + 10;
  localparam int PW = CW + FRAC_BITS + 1;

  // entry field offsets
  localparam int OFF_S0 = ROW_IDX_BITS;
  localparam int OFF_S1 = OFF_S0 + SAMPLE_BITS;
  localparam int OFF_S2 = OFF_S1 + SAMPLE_BITS;
  localparam int OFF_S3 = OFF_S2 + SAMPLE_BITS;
  localparam int OFF_FH = OFF_S3 + SAMPLE_BITS;
  localparam int OFF_FV = OFF_FH + FRAC_BITS;

  localparam logic signed [PW-1:0] HALF_F  = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] HALF_F1 = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [CW-1:0] HALF_O  = {{(CW-1){1'b0}}, 1'b1} << (EXTRA_BITS - 1);
  localparam logic signed [CW-1:0] SAT_HI  = {{(CW-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_LO  = {{(CW-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

  back_state_t state, state_next;

  logic signed [CW-1:0]    v0, v1, v2, v3;
  logic signed [CW-1:0]    d1, d2, d3;
  logic signed [CW-1:0]    acc;
  logic signed [CW-1:0]    col_res;
  logic signed [RW-1:0]    rr0, rr1, rr2;
  logic [FRAC_BITS-1:0]    t;
  logic [FRAC_BITS-1:0]    tv;
  logic [ROW_IDX_BITS-1:0] idx;
  logic                    col;
  logic signed [PW-1:0]    prod;

  logic                    out_free;
  logic                    load_row;
  logic                    do_diff;
  logic                    do_mul;
  logic                    sel_d3;
  logic                    do_inner;
  logic                    do_mid;
  logic                    do_res;
  logic                    load_out;

  logic [SAMPLE_BITS-1:0]  e_s0, e_s1, e_s2, e_s3;
  logic signed [FRAC_BITS:0] t_s;
  logic signed [CW-1:0]    mul_a;
  logic signed [PW-1:0]    rnd_f, rnd_f1;
  logic signed [CW-1:0]    rf, rf1;
  logic signed [CW-1:0]    res_c;
  logic signed [CW-1:0]    vr;
  logic signed [OUT_BITS-1:0] value_next;

  // entry unpacking
  assign e_s0 = entry[OFF_S0 +: SAMPLE_BITS];
  assign e_s1 = entry[OFF_S1 +: SAMPLE_BITS];
  assign e_s2 = entry[OFF_S2 +: SAMPLE_BITS];
  assign e_s3 = entry[OFF_S3 +: SAMPLE_BITS];

  assign out_free = !value_valid || !value_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!status.empty) state_next = ST_DIFF;
      end
      ST_DIFF: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_ADD3;
      ST_ADD3: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_ADD2;
      ST_ADD2: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_ADD1;
      ST_ADD1: begin
        if (col) begin
          state_next = ST_DONE;
        end else if (idx == LAST_ROW) begin
          state_next = ST_DIFF;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    load_row = 1'b0;
    do_diff  = 1'b0;
    do_mul   = 1'b0;
    sel_d3   = 1'b0;
    do_inner = 1'b0;
    do_mid   = 1'b0;
    do_res   = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: load_row = !status.empty;
      ST_DIFF: do_diff  = 1'b1;
      ST_MUL3: begin
        do_mul = 1'b1;
        sel_d3 = 1'b1;
      end
      ST_ADD3: do_inner = 1'b1;
      ST_MUL2: do_mul   = 1'b1;
      ST_ADD2: do_mid   = 1'b1;
      ST_MUL1: do_mul   = 1'b1;
      ST_ADD1: do_res   = 1'b1;
      ST_DONE: load_out = out_free;
      default: load_row = 1'b0;
    endcase
  end

  assign pop = load_row;

  // shared multiplier operands and rounding of the product
  assign t_s    = {1'b0, t};
  assign mul_a  = sel_d3 ? d3 : acc;
  assign rnd_f  = (prod + HALF_F) >>> FRAC_BITS;
  assign rnd_f1 = (prod + HALF_F1) >>> (FRAC_BITS + 1);
  assign rf     = rnd_f[CW-1:0];
  assign rf1    = rnd_f1[CW-1:0];
  assign res_c  = v1 + rf1;

  // final rounding and saturation
  assign vr = (col_res + HALF_O) >>> EXTRA_BITS;
  always_comb begin
    priority if (vr > SAT_HI) begin
      value_next = SAT_HI[OUT_BITS-1:0];
    end else if (vr < SAT_LO) begin
      value_next = SAT_LO[OUT_BITS-1:0];
    end else begin
      value_next = vr[OUT_BITS-1:0];
    end
  end

  // state, output valid and column-pass flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      value_valid <= 1'b0;
      col         <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        value_valid <= 1'b1;
      end else if (value_valid && !value_stall) begin
        value_valid <= 1'b0;
      end
      if (load_row) begin
        col <= 1'b0;
      end else if (do_res && !col && idx == LAST_ROW) begin
        col <= 1'b1;
      end
    end
  end

  // cubic datapath
  always_ff @(posedge clk) begin
    if (load_row) begin
      v0  <= {{(CW-SAMPLE_BITS-EXTRA_BITS){1'b0}}, e_s0, {EXTRA_BITS{1'b0}}};
      v1  <= {{(CW-SAMPLE_BITS-EXTRA_BITS){1'b0}}, e_s1, {EXTRA_BITS{1'b0}}};
      v2  <= {{(CW-SAMPLE_BITS-EXTRA_BITS){1'b0}}, e_s2, {EXTRA_BITS{1'b0}}};
      v3  <= {{(CW-SAMPLE_BITS-EXTRA_BITS){1'b0}}, e_s3, {EXTRA_BITS{1'b0}}};
      t   <= entry[OFF_FH +: FRAC_BITS];
      tv  <= entry[OFF_FV +: FRAC_BITS];
      idx <= entry[ROW_IDX_BITS-1:0];
    end
    // difference terms of the cubic
    if (do_diff) begin
      d1 <= v2 - v0;
      d2 <= (v0 <<< 1) - ((v1 <<< 2) + v1) + (v2 <<< 2) - v3;
      d3 <= ((v1 - v2) <<< 1) + (v1 - v2) + v3 - v0;
    end
    if (do_mul) begin
      prod <= t_s * mul_a;
    end
    if (do_inner) begin
      acc <= d2 + rf;
    end
    if (do_mid) begin
      acc <= d1 + rf;
    end
    // row result: store it, start the column pass on the last row, or keep the column result
    if (do_res) begin
      if (col) begin
        col_res <= res_c;
      end else begin
        unique case (idx)
          2'd0:    rr0 <= res_c[RW-1:0];
          2'd1:    rr1 <= res_c[RW-1:0];
          2'd2:    rr2 <= res_c[RW-1:0];
          default: begin
            v0 <= {{(CW-RW){rr0[RW-1]}}, rr0};
            v1 <= {{(CW-RW){rr1[RW-1]}}, rr1};
            v2 <= {{(CW-RW){rr2[RW-1]}}, rr2};
            v3 <= res_c;
            t  <= tv;
          end
        endcase
      end
    end
    if (load_out) begin
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bicubic_cell_interpolator.sv =====
// top level of the bicubic cell interpolator: front, queue and back parts
// depends on bci_pkg, bci_front, bci_fifo and bci_back
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   row in   | sample_valid / sample_stall | sample_0..sample_3, frac_h, frac_v
//   value out| value_valid / value_stall   | value (18-bit signed)
//
// each row runs the back part's shared multiplier sequencer (difference
// terms, three multiply/add steps); a cell's fourth row runs it again for
// the column pass and output load; a two-entry queue takes rows meanwhile.
// synchronous reset clears the row index, the queue and the output valid.
// a stalled output holds the back part only when the next value is ready.
`default_nettype none

module bicubic_cell_interpolator #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  sample_valid,
  output logic                                 sample_stall,
  input  wire  [SAMPLE_BITS-1:0]               sample_0,
  input  wire  [SAMPLE_BITS-1:0]               sample_1,
  input  wire  [SAMPLE_BITS-1:0]               sample_2,
  input  wire  [SAMPLE_BITS-1:0]               sample_3,
  input  wire  [FRAC_BITS-1:0]                 frac_h,
  input  wire  [FRAC_BITS-1:0]                 frac_v,
  output logic                                 value_valid,
  input  wire                                  value_stall,
  output logic signed [bci_pkg::OUT_BITS-1:0]  value
);
  import bci_pkg::*;

  localparam int ENTRY_W = 4 * SAMPLE_BITS + 2 * FRAC_BITS + ROW_IDX_BITS;

  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] rd_entry;
  fifo_status_t       status;

  // row intake and classification
  bci_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_0     (sample_0),
    .sample_1     (sample_1),
    .sample_2     (sample_2),
    .sample_3     (sample_3),
    .frac_h       (frac_h),
    .frac_v       (frac_v),
    .status       (status),
    .push         (push),
    .entry        (wr_entry)
  );

  // decoupling queue
  bci_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .status  (status)
  );

  // cubic evaluation and output register
  bci_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (rd_entry),
    .status      (status),
    .pop         (pop),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value)
  );

endmodule

`default_nettype wire

// ===== rtl/bci_checker.sv =====
// port-level checker for the bicubic cell interpolator, bound to the top level
// depends on bci_pkg and bicubic_cell_interpolator_macros.svh
`default_nettype none
`include "bicubic_cell_interpolator_macros.svh"

module bci_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 sample_valid,
  input wire                                 sample_stall,
  input wire                                 value_valid,
  input wire                                 value_stall,
  input wire [bci_pkg::OUT_BITS-1:0]         value
);
  import bci_pkg::*;

  logic [ROW_IDX_BITS-1:0] row_mod;
  logic [2:0]              pending;
  logic                    row_xfer;
  logic                    cell_in;
  logic                    value_xfer;

  assign row_xfer   = sample_valid && !sample_stall;
  assign cell_in    = row_xfer && (row_mod == LAST_ROW);
  assign value_xfer = value_valid && !value_stall;

  // count cells whose last row went in but whose value is not out yet
  always_ff @(posedge clk) begin
    if (rst) begin
      row_mod <= '0;
      pending <= '0;
    end else begin
      if (row_xfer) begin
        row_mod <= row_mod + 1'b1;
      end
      unique case ({cell_in, value_xfer})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  `BCI_ASSERT_NXT(a_value_hold, clk, rst, value_valid && value_stall, value_valid && $stable(value), "stalled value changed")
  `BCI_ASSERT_RST(a_reset_clear, clk, rst, !value_valid && !sample_stall, "not idle after reset")
  `BCI_ASSERT_IMP(a_value_has_cell, clk, rst, value_valid, pending != 3'd0, "value without a full cell")

endmodule

bind bicubic_cell_interpolator bci_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .value_valid  (value_valid),
  .value_stall  (value_stall),
  .value        (value)
);

`default_nettype wire

// ===== tb/bicubic_cell_interpolator_tb.sv =====
// self-checking testbench for the bicubic cell interpolator
// depends on bci_pkg and the rtl top bicubic_cell_interpolator
`timescale 1ns / 100ps

module testbench;
  import bci_pkg::*;

  localparam int SAMPLE_BITS    = 16;
  localparam int FRAC_BITS      = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int DIRECTED_CELLS = 6;

  typedef logic [SAMPLE_BITS-1:0]      sample_t;
  typedef logic [FRAC_BITS-1:0]        frac_t;
  typedef logic signed [OUT_BITS-1:0]  pixel_t;

  localparam sample_t SAMPLE_MAX = '1;
  localparam frac_t   FRAC_MAX   = '1;
  localparam frac_t   FRAC_HALF  = frac_t'(1) << (FRAC_BITS - 1);

  // expected pixel tracker: predicts every cell and checks output transfers
  class cell_scoreboard;
    localparam longint PIXEL_MAX = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    localparam longint PIXEL_MIN = -(longint'(1) <<< (OUT_BITS - 1));

    logic [ROW_IDX_BITS-1:0] rows_taken;
    longint                  row_partials[3];
    pixel_t                  expected_pixels[$];
    int                      errors;

    function new();
      rows_taken = '0;
      errors     = 0;
    endfunction

    // round to nearest, ties toward plus infinity (arithmetic shift floors)
    function longint round_shift(longint x, int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // catmull-rom cubic with a = -0.5 in horner form at fraction t
    function longint catmull_rom(longint v0, longint v1, longint v2, longint v3,
                                 longint t);
      longint d1, d2, d3, inner, mid;
      d1    = v2 - v0;
      d2    = 2 * v0 - 5 * v1 + 4 * v2 - v3;
      d3    = 3 * (v1 - v2) + v3 - v0;
      inner = d2 + round_shift(t * d3, FRAC_BITS);
      mid   = d1 + round_shift(t * inner, FRAC_BITS);
      return v1 + round_shift(t * mid, FRAC_BITS + 1);
    endfunction

    // one accepted row: horizontal pass, column pass on the last row
    function void note_row(sample_t s0, sample_t s1, sample_t s2, sample_t s3,
                           frac_t fh, frac_t fv);
      longint row_val, col_val, pixel;
      row_val = catmull_rom(longint'(s0) <<< EXTRA_BITS, longint'(s1) <<< EXTRA_BITS,
                            longint'(s2) <<< EXTRA_BITS, longint'(s3) <<< EXTRA_BITS,
                            longint'(fh));
      if (rows_taken != LAST_ROW) begin
        row_partials[rows_taken] = row_val;
        rows_taken++;
      end else begin
        col_val = catmull_rom(row_partials[0], row_partials[1], row_partials[2],
                              row_val, longint'(fv));
        pixel = round_shift(col_val, EXTRA_BITS);
        if (pixel > PIXEL_MAX) pixel = PIXEL_MAX;
        if (pixel < PIXEL_MIN) pixel = PIXEL_MIN;
        expected_pixels.push_back(pixel_t'(pixel));
        rows_taken = '0;
      end
    endfunction

    // one accepted output value against the oldest prediction
    function void check_value(pixel_t actual);
      pixel_t expected;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected value %0d with nothing outstanding", $time, actual);
        errors++;
      end else begin
        expected = expected_pixels.pop_front();
        if (actual !== expected) begin
          $display("%0t: value mismatch expected %0d actual %0d", $time, expected, actual);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return expected_pixels.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    sample_valid;
  logic    sample_stall;
  sample_t sample_0, sample_1, sample_2, sample_3;
  frac_t   frac_h, frac_v;
  logic    value_valid;
  logic    value_stall;
  pixel_t  value;

  cell_scoreboard pixel_board = new();
  int             send_idle_pct;
  int             recv_stall_pct;
  int             quiet_cycles;

  bicubic_cell_interpolator #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_0    (sample_0),
    .sample_1    (sample_1),
    .sample_2    (sample_2),
    .sample_3    (sample_3),
    .frac_h      (frac_h),
    .frac_v      (frac_v),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value)
  );

  always #1 clk = ~clk;

  // output side: check each transfer, then pick the next stall at random
  always @(posedge clk) begin
    if (!rst && value_valid && !value_stall) pixel_board.check_value(value);
    value_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (value_valid && !value_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one row transfer, with random idle cycles ahead of it
  task automatic send_row(input sample_t s0, input sample_t s1, input sample_t s2,
                          input sample_t s3, input frac_t fh, input frac_t fv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_0     <= s0;
    sample_1     <= s1;
    sample_2     <= s2;
    sample_3     <= s3;
    frac_h       <= fh;
    frac_v       <= fv;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pixel_board.note_row(s0, s1, s2, s3, fh, fv);
  endtask

  // hold the input idle until every predicted value has come out
  task automatic drain_outputs();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pixel_board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic sample_t pick_sample(int mode, sample_t base);
    case (mode)
      0:       return sample_t'($urandom());
      1:       return $urandom_range(0, 1) ? SAMPLE_MAX : '0;
      default: return sample_t'(base + sample_t'($urandom_range(0, 511)) - 256);
    endcase
  endfunction

  function automatic frac_t pick_frac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FRAC_MAX;
      default: return frac_t'($urandom());
    endcase
  endfunction

  // directed sample for a cell: flats, extremes, ringing patterns both ways
  function automatic sample_t directed_sample(int cell_idx, int row, int col);
    case (cell_idx)
      0:       return '0;
      1:       return SAMPLE_MAX;
      2:       return ((row + col) % 2 == 1) ? SAMPLE_MAX : '0;
      3:       return (row inside {1, 2} && col inside {1, 2}) ? SAMPLE_MAX : '0;
      4:       return (row inside {1, 2} && col inside {1, 2}) ? '0 : SAMPLE_MAX;
      default: return sample_t'(col * 20000 + row * 3000 + 77);
    endcase
  endfunction

  // random cells, each a full well-formed run of four rows
  task automatic send_random_cells(input int cells, input bit pause_midway);
    sample_t base;
    int      mode;
    for (int c = 0; c < cells; c++) begin
      if (pause_midway && c == cells / 2) drain_outputs();
      for (int r = 0; r < 4; r++) begin
        base = sample_t'($urandom());
        mode = $urandom_range(0, 99) < 60 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        send_row(pick_sample(mode, base), pick_sample(mode, base),
                 pick_sample(mode, base), pick_sample(mode, base),
                 pick_frac(), pick_frac());
      end
    end
  endtask

  initial begin
    frac_t fh, fv;
    rst            <= 1'b1;
    sample_valid   <= 1'b0;
    sample_0       <= '0;
    sample_1       <= '0;
    sample_2       <= '0;
    sample_3       <= '0;
    frac_h         <= '0;
    frac_v         <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed cells: zero and full fractions, halfway, smallest step
    send_idle_pct  = 24;
    recv_stall_pct = 58;
    for (int c = 0; c < DIRECTED_CELLS; c++) begin
      for (int r = 0; r < 4; r++) begin
        case (c)
          0:       begin fh = '0;        fv = '0;        end
          1:       begin fh = FRAC_MAX;  fv = FRAC_MAX;  end
          5:       begin fh = frac_t'(1); fv = (r == 3) ? FRAC_MAX : frac_t'(r * 9999); end
          default: begin fh = FRAC_HALF; fv = FRAC_HALF; end
        endcase
        send_row(directed_sample(c, r, 0), directed_sample(c, r, 1),
                 directed_sample(c, r, 2), directed_sample(c, r, 3), fh, fv);
      end
    end

    // random phases with swapped and then no idling
    send_random_cells(56, 1'b0);
    send_idle_pct  = 58;
    recv_stall_pct = 24;
    send_random_cells(56, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_cells(58, 1'b0);

    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pixel_board.errors == 0 && pixel_board.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
